// File: rtl/tcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcl_pkg;

  localparam int unsigned PERIOD_WIDTH_DEF = 16;
  localparam int unsigned PERIOD_OUT_W     = 16;

  localparam int unsigned NKEYS      = 7;
  localparam int unsigned NLINE_KEYS = 5;
  localparam int unsigned KEY_LOG    = 5;
  localparam int unsigned KEY_PERIOD = 6;

  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // line_position saturates here
  localparam logic [3:0] POS_MAX = 4'd8;

  typedef enum logic [3:0] {
    EV_LOG_CHAR   = 4'd0,
    EV_OFF        = 4'd1,
    EV_SCALE_F    = 4'd2,
    EV_SCALE_C    = 4'd3,
    EV_STOP       = 4'd4,
    EV_START      = 4'd5,
    EV_LOG_END    = 4'd6,
    EV_PERIOD_SET = 4'd7,
    EV_BOGUS      = 4'd8
  } event_kind_e;

  // Keyword text, right-justified: the first character is the highest used byte
  localparam logic [63:0] KEY_STR [NKEYS] = '{
    64'("OFF\n"), 64'("SCALE=F\n"), 64'("SCALE=C\n"), 64'("STOP\n"),
    64'("START\n"), 64'("LOG "), 64'("PERIOD=")
  };
  localparam int unsigned KEY_LEN [NKEYS] = '{4, 8, 8, 5, 6, 4, 7};
  localparam event_kind_e KEY_EVENT [NLINE_KEYS] = '{
    EV_OFF, EV_SCALE_F, EV_SCALE_C, EV_STOP, EV_START
  };

  localparam logic [3:0] LOG_PREFIX_LAST   = 4'(KEY_LEN[KEY_LOG] - 1);
  localparam logic [3:0] PERIOD_PREFIX_LAST = 4'(KEY_LEN[KEY_PERIOD] - 1);
  localparam logic [3:0] PERIOD_DIGITS_POS = 4'(KEY_LEN[KEY_PERIOD]);

  typedef struct packed {
    event_kind_e              kind;
    logic [7:0]               log_char;
    logic [PERIOD_OUT_W-1:0]  period;
    logic                     celsius;
    logic                     stopped;
  } tcl_event_t;

  // Character of keyword k at line position p; zero past the keyword end
  function automatic logic [7:0] key_char(input int unsigned k, input logic [3:0] p);
    int unsigned idx;
    logic [63:0] s;
    s = KEY_STR[k];
    if (32'(p) < KEY_LEN[k]) begin
      idx = KEY_LEN[k] - 1 - 32'(p);
      return s[idx*8 +: 8];
    end
    return 8'd0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcl_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // take a new item whenever the held one leaves or none is held
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// File: rtl/tcl_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_parser #(
  parameter int unsigned PERIOD_WIDTH = tcl_pkg::PERIOD_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  byte_i,
  input  wire logic        commit_i,
  output logic             emit_o,
  output tcl_pkg::tcl_event_t ev_o
);

  localparam int unsigned AW = PERIOD_WIDTH + 4;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST = PERIOD_WIDTH'(1);

  logic                      halted_q, halted_d;
  logic                      stopped_q, stopped_d;
  logic                      celsius_q, celsius_d;
  logic [PERIOD_WIDTH-1:0]   period_q, period_d;
  logic [3:0]                pos_q, pos_d;
  logic [tcl_pkg::NKEYS-1:0] cand_q, cand_d, cand_m;
  logic                      log_q, log_d;
  logic [PERIOD_WIDTH-1:0]   acc_q, acc_d;
  logic                      digits_q, digits_d;
  logic                      bad_q, bad_d;

  logic [AW-1:0]             acc_ext, acc_next;
  logic [PERIOD_WIDTH-1:0]   acc_sat;
  logic [PERIOD_WIDTH+tcl_pkg::PERIOD_OUT_W-1:0] period_ext;
  logic                      is_digit;
  logic                      new_line;
  logic                      period_ok;
  tcl_pkg::event_kind_e      kind;

  // times ten plus digit, saturated
  always_comb begin
    acc_ext  = {4'b0, acc_q};
    acc_next = (acc_ext << 3) + (acc_ext << 1) + {{PERIOD_WIDTH{1'b0}}, byte_i[3:0]};
    acc_sat  = (acc_next[AW-1:PERIOD_WIDTH] != 4'd0) ? PERIOD_MAX
                                                     : acc_next[PERIOD_WIDTH-1:0];
  end

  assign is_digit = (byte_i >= tcl_pkg::CH_ZERO) && (byte_i <= tcl_pkg::CH_NINE);

  // drop keywords that no longer match at this position
  always_comb begin
    cand_m = cand_q;
    for (int unsigned k = 0; k < tcl_pkg::NKEYS; k++) begin
      if (32'(pos_q) >= tcl_pkg::KEY_LEN[k] || tcl_pkg::key_char(k, pos_q) != byte_i) begin
        cand_m[k] = 1'b0;
      end
    end
  end

  always_comb begin
    halted_d  = halted_q;
    stopped_d = stopped_q;
    celsius_d = celsius_q;
    period_d  = period_q;
    pos_d     = pos_q;
    cand_d    = cand_q;
    log_d     = log_q;
    acc_d     = acc_q;
    digits_d  = digits_q;
    bad_d     = bad_q;
    new_line  = 1'b0;
    emit_o    = 1'b0;
    kind      = tcl_pkg::EV_BOGUS;
    period_ok = digits_q && !bad_q;

    if (halted_q) begin
      emit_o = 1'b0;
    end else if (log_q) begin
      emit_o = 1'b1;
      if (byte_i == tcl_pkg::CH_LF) begin
        kind     = tcl_pkg::EV_LOG_END;
        new_line = 1'b1;
      end else begin
        kind = tcl_pkg::EV_LOG_CHAR;
      end
    end else if (pos_q == tcl_pkg::PERIOD_DIGITS_POS && cand_q[tcl_pkg::KEY_PERIOD]) begin
      if (byte_i == tcl_pkg::CH_LF) begin
        emit_o   = 1'b1;
        new_line = 1'b1;
        if (period_ok) begin
          period_d = acc_q;
          kind     = tcl_pkg::EV_PERIOD_SET;
        end
      end else if (is_digit) begin
        acc_d    = acc_sat;
        digits_d = 1'b1;
      end else begin
        bad_d = 1'b1;
      end
    end else begin
      cand_d = cand_m;
      if (byte_i == tcl_pkg::CH_LF) begin
        emit_o   = 1'b1;
        new_line = 1'b1;
        for (int unsigned k = 0; k < tcl_pkg::NLINE_KEYS; k++) begin
          if (cand_m[k] && (32'(pos_q) + 32'd1 == tcl_pkg::KEY_LEN[k])) begin
            kind = tcl_pkg::KEY_EVENT[k];
          end
        end
        case (kind)
          tcl_pkg::EV_OFF:     halted_d  = 1'b1;
          tcl_pkg::EV_SCALE_F: celsius_d = 1'b0;
          tcl_pkg::EV_SCALE_C: celsius_d = 1'b1;
          tcl_pkg::EV_STOP:    stopped_d = 1'b1;
          tcl_pkg::EV_START:   stopped_d = 1'b0;
          default:             halted_d  = halted_q;
        endcase
      end else if (cand_m[tcl_pkg::KEY_LOG] && pos_q == tcl_pkg::LOG_PREFIX_LAST) begin
        log_d = 1'b1;
      end else if (cand_m[tcl_pkg::KEY_PERIOD] && pos_q == tcl_pkg::PERIOD_PREFIX_LAST) begin
        cand_d = '0;
        cand_d[tcl_pkg::KEY_PERIOD] = 1'b1;
        pos_d  = tcl_pkg::PERIOD_DIGITS_POS;
      end else begin
        if (pos_q < tcl_pkg::POS_MAX) begin
          pos_d = pos_q + 4'd1;
        end
        if (cand_m == '0) begin
          bad_d = 1'b1;
        end
      end
    end

    if (new_line) begin
      pos_d    = 4'd0;
      cand_d   = '1;
      log_d    = 1'b0;
      acc_d    = '0;
      digits_d = 1'b0;
      bad_d    = 1'b0;
    end
  end

  // result fields show the state after this byte
  always_comb begin
    period_ext  = {{tcl_pkg::PERIOD_OUT_W{1'b0}}, period_d};
    ev_o.kind     = kind;
    ev_o.log_char = (kind == tcl_pkg::EV_LOG_CHAR) ? byte_i : 8'd0;
    ev_o.period   = period_ext[tcl_pkg::PERIOD_OUT_W-1:0];
    ev_o.celsius  = celsius_d;
    ev_o.stopped  = stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q  <= 1'b0;
      stopped_q <= 1'b0;
      celsius_q <= 1'b0;
      period_q  <= PERIOD_RST;
      pos_q     <= 4'd0;
      cand_q    <= '1;
      log_q     <= 1'b0;
      acc_q     <= '0;
      digits_q  <= 1'b0;
      bad_q     <= 1'b0;
    end else if (commit_i) begin
      halted_q  <= halted_d;
      stopped_q <= stopped_d;
      celsius_q <= celsius_d;
      period_q  <= period_d;
      pos_q     <= pos_d;
      cand_q    <= cand_d;
      log_q     <= log_d;
      acc_q     <= acc_d;
      digits_q  <= digits_d;
      bad_q     <= bad_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcl_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire tcl_pkg::tcl_event_t ev_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tcl_pkg::tcl_event_t      ev_o
);

  logic                valid_q, valid_d;
  tcl_pkg::tcl_event_t ev_q;

  // room for a new result when empty or the held one leaves now
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= ev_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ev_o        = ev_q;

endmodule

`default_nettype wire

// File: rtl/text_command_line_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o   in_byte_i[7:0]
// out       output     out_valid_o / out_ready_i event_kind_o[3:0], log_char_o[7:0],
//                                                period_value_o[15:0],
//                                                scale_is_celsius_o, reports_stopped_o
//
// One byte per cycle sustained while results can leave. A byte is held in the input
// register, is parsed there and, if it ends a line or carries log payload, its result
// is loaded into the output register as the byte leaves. Bytes that give no result never wait.
// Reset (async, active low) returns to Fahrenheit, running, period one, new line.
// A held result stalls only a byte that would give another result; the input
// register then holds it and in_ready_o falls.

module text_command_line_parser_top #(
  parameter int unsigned PERIOD_WIDTH = tcl_pkg::PERIOD_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       event_kind_o,
  output logic [7:0]       log_char_o,
  output logic [15:0]      period_value_o,
  output logic             scale_is_celsius_o,
  output logic             reports_stopped_o
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_go;
  logic                emit;
  logic                out_free;
  tcl_pkg::tcl_event_t ev_new;
  tcl_pkg::tcl_event_t ev_out;

  // advance the held byte unless its result has nowhere to go
  assign s1_go = s1_valid && (!emit || out_free);

  tcl_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (s1_go),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  // parse state and the keyword matcher; commits only when the byte advances
  tcl_parser #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (s1_byte),
    .commit_i (s1_go),
    .emit_o   (emit),
    .ev_o     (ev_new)
  );

  tcl_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_go && emit),
    .ev_i        (ev_new),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ev_o        (ev_out)
  );

  assign event_kind_o       = ev_out.kind;
  assign log_char_o         = ev_out.log_char;
  assign period_value_o     = ev_out.period;
  assign scale_is_celsius_o = ev_out.celsius;
  assign reports_stopped_o  = ev_out.stopped;

endmodule

`default_nettype wire

// File: rtl/tcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  event_kind_o,
  input wire logic [7:0]  log_char_o,
  input wire logic [15:0] period_value_o,
  input wire logic        scale_is_celsius_o,
  input wire logic        reports_stopped_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(log_char_o) && $stable(period_value_o))
    else $error("result changed while stalled");

  // log_char is zero for every kind but a log character
  a_log_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != tcl_pkg::EV_LOG_CHAR |-> log_char_o == 8'd0)
    else $error("log_char set on a non-log result");

  // status bits agree with the command just reported
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (event_kind_o != tcl_pkg::EV_SCALE_C || scale_is_celsius_o) &&
      (event_kind_o != tcl_pkg::EV_SCALE_F || !scale_is_celsius_o) &&
      (event_kind_o != tcl_pkg::EV_STOP || reports_stopped_o) &&
      (event_kind_o != tcl_pkg::EV_START || !reports_stopped_o))
    else $error("status disagrees with reported command");

  // nothing follows OFF until reset
  a_off_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && event_kind_o == tcl_pkg::EV_OFF |=> !out_valid_o)
    else $error("result after OFF");

  // the event kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_kind_o <= tcl_pkg::EV_BOGUS)
    else $error("event kind out of range");

endmodule

bind text_command_line_parser_top tcl_checker u_tcl_checker (.*);

`default_nettype wire

// File: verif/tb_text_command_line_parser_top.sv
`timescale 1ns / 1ps

module tb_text_command_line_parser_top;

  localparam int unsigned RANDOM_ITEMS   = 390;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 160;
  localparam int unsigned PERIOD_MAX     = (1 << tcl_pkg::PERIOD_WIDTH_DEF) - 1;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] event_kind_o;
  logic [7:0] log_char_o;
  logic [15:0] period_value_o;
  logic       scale_is_celsius_o;
  logic       reports_stopped_o;

  text_command_line_parser_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_kind_o      (event_kind_o),
    .log_char_o        (log_char_o),
    .period_value_o    (period_value_o),
    .scale_is_celsius_o(scale_is_celsius_o),
    .reports_stopped_o (reports_stopped_o)
  );

  // 2 ns period: low for 1 ns, high for 1 ns
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line parser predictor: its own copy of the parser state, advanced once per
  // accepted item. Every result it predicts goes to the back of expected_events.
  // ---------------------------------------------------------------------------
  // Keyword text; the five whole-line keywords carry their newline, the two
  // prefixes do not. Bit k of line_candidates tracks keyword k.
  string keyword_text [tcl_pkg::NKEYS] = '{
    "OFF\n", "SCALE=F\n", "SCALE=C\n", "STOP\n", "START\n", "LOG ", "PERIOD="
  };
  tcl_pkg::event_kind_e line_event [tcl_pkg::NLINE_KEYS] = '{
    tcl_pkg::EV_OFF, tcl_pkg::EV_SCALE_F, tcl_pkg::EV_SCALE_C, tcl_pkg::EV_STOP,
    tcl_pkg::EV_START
  };

  logic             halted_q  = 1'b0;
  logic             stopped_q = 1'b0;
  logic             celsius_q = 1'b0;
  logic [15:0]      period_q  = 16'd1;
  int unsigned      line_pos  = 0;
  logic [tcl_pkg::NKEYS-1:0] line_candidates = '1;
  logic             in_log = 1'b0;
  int unsigned      digit_acc = 0;
  logic             digits_seen = 1'b0;
  logic             line_bad = 1'b0;

  tcl_pkg::tcl_event_t expected_events [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;

  function automatic void restart_line();
    line_pos        = 0;
    line_candidates = '1;
    in_log          = 1'b0;
    digit_acc       = 0;
    digits_seen     = 1'b0;
    line_bad        = 1'b0;
  endfunction

  // The status fields always show the state after the step that caused the event
  function automatic void push_event(input tcl_pkg::event_kind_e kind,
                                     input logic [7:0] ch);
    tcl_pkg::tcl_event_t ev;
    ev.kind     = kind;
    ev.log_char = ch;
    ev.period   = period_q;
    ev.celsius  = celsius_q;
    ev.stopped  = stopped_q;
    expected_events.push_back(ev);
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    int p;
    int k;
    tcl_pkg::event_kind_e kind;
    // after OFF nothing is looked at again
    if (halted_q) return;

    // log payload: pass every byte out until the newline
    if (in_log) begin
      if (b == tcl_pkg::CH_LF) begin
        restart_line();
        push_event(tcl_pkg::EV_LOG_END, 8'h00);
      end else begin
        push_event(tcl_pkg::EV_LOG_CHAR, b);
      end
      return;
    end

    // period digits: accumulate with saturation, any non-digit spoils the line
    if (line_pos == tcl_pkg::PERIOD_DIGITS_POS && line_candidates[tcl_pkg::KEY_PERIOD]) begin
      if (b == tcl_pkg::CH_LF) begin
        if (digits_seen && !line_bad) begin
          period_q = digit_acc[15:0];
          kind     = tcl_pkg::EV_PERIOD_SET;
        end else begin
          kind = tcl_pkg::EV_BOGUS;
        end
        restart_line();
        push_event(kind, 8'h00);
        return;
      end
      if (b >= tcl_pkg::CH_ZERO && b <= tcl_pkg::CH_NINE) begin
        digit_acc = digit_acc * 10 + (b - tcl_pkg::CH_ZERO);
        if (digit_acc > PERIOD_MAX) digit_acc = PERIOD_MAX;
        digits_seen = 1'b1;
      end else begin
        line_bad = 1'b1;
      end
      return;
    end

    // drop every keyword that no longer matches at this position
    p = line_pos;
    for (k = 0; k < tcl_pkg::NKEYS; k++) begin
      if (line_candidates[k] && (p >= keyword_text[k].len() || keyword_text[k][p] != b))
        line_candidates[k] = 1'b0;
    end

    if (b == tcl_pkg::CH_LF) begin
      kind = tcl_pkg::EV_BOGUS;
      for (k = 0; k < tcl_pkg::NLINE_KEYS; k++) begin
        if (line_candidates[k] && p + 1 == keyword_text[k].len()) kind = line_event[k];
      end
      case (kind)
        tcl_pkg::EV_OFF:     halted_q  = 1'b1;
        tcl_pkg::EV_SCALE_F: celsius_q = 1'b0;
        tcl_pkg::EV_SCALE_C: celsius_q = 1'b1;
        tcl_pkg::EV_STOP:    stopped_q = 1'b1;
        tcl_pkg::EV_START:   stopped_q = 1'b0;
        default: ;
      endcase
      restart_line();
      push_event(kind, 8'h00);
      return;
    end

    // complete prefixes switch mode on their last byte
    if (line_candidates[tcl_pkg::KEY_LOG]
        && p + 1 == keyword_text[tcl_pkg::KEY_LOG].len()) begin
      in_log = 1'b1;
      return;
    end
    if (line_candidates[tcl_pkg::KEY_PERIOD]
        && p + 1 == keyword_text[tcl_pkg::KEY_PERIOD].len()) begin
      line_candidates                      = '0;
      line_candidates[tcl_pkg::KEY_PERIOD] = 1'b1;
      line_pos                             = tcl_pkg::PERIOD_DIGITS_POS;
      return;
    end
    if (line_pos < tcl_pkg::POS_MAX) line_pos++;
    if (line_candidates == '0) line_bad = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. Drive at the
  // falling edge, detect acceptance at the rising edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    // hold valid and the byte until the block takes the item
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input logic [7:0] body [$]);
    foreach (body[i]) send_byte(body[i]);
    send_byte(tcl_pkg::CH_LF);
  endtask

  // Append keyword text without its newline
  task automatic add_text(ref logic [7:0] body [$], input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (s[i] != tcl_pkg::CH_LF) body.push_back(s[i]);
    end
  endtask

  // Any byte but the newline, evenly spread over the other 255 values
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= tcl_pkg::CH_LF) b++;
    return b;
  endfunction

  // Lower valid and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_events.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating stall pattern, renewed when its random age runs
  // out; now and then the pattern is all ones for a stall-free stretch. A request from a
  // test makes it hold ready low for a long stretch set by LONG_HOLD.
  // ---------------------------------------------------------------------------
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned pattern_age = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age   = $urandom_range(16, 96);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      pattern_age--;
      out_ready_i   <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    tcl_pkg::tcl_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual event_kind %0d",
                 $time, event_kind_o);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 16'(want.kind), 16'(event_kind_o));
        check_field("log_char", 16'(want.log_char), 16'(log_char_o));
        check_field("period_value", want.period, period_value_o);
        check_field("scale_is_celsius", 16'(want.celsius), 16'(scale_is_celsius_o));
        check_field("reports_stopped", 16'(want.stopped), 16'(reports_stopped_o));
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Exact whole-line keywords, and a lower-case near miss
  task automatic test_keywords();
    send_text("SCALE=C\n");
    send_text("STOP\n");
    send_text("START\n");
    send_text("STOP\n");
    send_text("SCALE=F\n");
    send_text("stop\n");
  endtask

  // Empty log, payload with the extreme bytes, short prefix
  task automatic test_log_lines();
    logic [7:0] body [$];
    send_text("LOG \n");
    add_text(body, "LOG ");
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h7F);
    body.push_back(8'h80);
    send_line(body);
    send_text("LOG\n");
  endtask

  // Missing digits, largest value, saturation, zero, a spoilt digit string
  task automatic test_period_lines();
    send_text("PERIOD=\n");
    send_text("PERIOD=65535\n");
    send_text("PERIOD=0\n");
    send_text("PERIOD=9999999\n");
    send_text("PERIOD=1a2\n");
    send_text("PERIOD=0042\n");
  endtask

  // Empty line, zero byte, over-long line, a truncated keyword and a wrong byte after PERIOD
  task automatic test_bogus_lines();
    logic [7:0] body [$];
    send_text("\n");
    body.push_back(8'h00);
    send_line(body);
    send_text("SCALE=CCCCC\n");
    send_text("STA\n");
    send_text("PERIODX\n");
  endtask

  // Hold ready low for a long stretch while log lines keep coming, so that
  // the block fills up and has to stall its input
  task automatic test_receiver_hold();
    logic [7:0] body [$];
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (3) begin
      body.delete();
      add_text(body, "LOG ");
      repeat (12) body.push_back(payload_byte());
      send_line(body);
      send_text("START\n");
    end
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed lines with random content, plus near misses and noise
  task automatic test_random_lines();
    logic [7:0] body [$];
    int unsigned stop_at;
    int unsigned n;
    int unsigned pos;
    logic [7:0] c;
    string alphabet;
    alphabet = "OFSCALETRPIDG= 0123456789";
    stop_at  = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      body.delete();
      // switch idling off and on now and then
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      case ($urandom_range(0, 11))
        0: add_text(body, "SCALE=F");
        1: add_text(body, "SCALE=C");
        2: add_text(body, "STOP");
        3: add_text(body, "START");
        4, 5: begin
          add_text(body, "LOG ");
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
          repeat (n) body.push_back(payload_byte());
        end
        6, 7, 8: begin
          add_text(body, "PERIOD=");
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
          repeat (n) body.push_back(tcl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          // sometimes spoil the digits with a stray byte
          if ($urandom_range(0, 2) == 0) begin
            do c = payload_byte(); while (c >= tcl_pkg::CH_ZERO && c <= tcl_pkg::CH_NINE);
            body.insert($urandom_range(7, body.size()), c);
          end
        end
        9, 10: begin
          add_text(body, keyword_text[$urandom_range(0, tcl_pkg::NKEYS - 1)]);
          case ($urandom_range(0, 2))
            0: begin
              pos = $urandom_range(0, body.size() - 1);
              do c = payload_byte(); while (c == body[pos]);
              body[pos] = c;
            end
            1: void'(body.pop_back());
            default: repeat ($urandom_range(1, 6)) body.push_back(payload_byte());
          endcase
        end
        default: begin
          n = $urandom_range(0, 12);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0)
              body.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            else
              body.push_back(payload_byte());
          end
        end
      endcase
      // keep OFF for the very end: it halts the block for good
      if (body.size() == 3 && body[0] == "O" && body[1] == "F" && body[2] == "F")
        body.push_back("F");
      send_line(body);
    end
    gaps_on = 1'b1;
  endtask

  // OFF halts the block; everything after it is taken and ignored
  task automatic test_halt();
    send_text("OFF\n");
    send_text("SCALE=C\n");
    repeat (30) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_keywords();
    test_log_lines();
    test_period_lines();
    test_bogus_lines();
    // pause the sender until every predicted result has come
    wait_drained();
    test_receiver_hold();
    wait_drained();
    test_random_lines();
    wait_drained();
    test_halt();
    wait_drained();

    // allow for a stray late result before judging
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
